FILE: design/egcl_pkg.sv
package egcl_pkg;

    // field and port widths fixed by the stream format
    localparam int CHAN_W     = 4;
    localparam int DRAW_W     = 16;
    localparam int METRIC_W   = 8;
    localparam int REWARD_W   = 16;
    localparam int VALUE_W    = 24;
    localparam int LR_W       = 9;
    localparam int SCALE_W    = 7;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // request kinds carried on s_tuser
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_THRESHOLD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PENALTY    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REWARD_SCALE      = 4'd3;

    // register reset values
    localparam logic [DRAW_W-1:0]          THRESHOLD_RST = 16'd6554;
    localparam logic [LR_W-1:0]            LR_RST        = 9'd26;
    localparam logic signed [REWARD_W-1:0] PENALTY_RST   = -16'sd10;
    localparam logic [SCALE_W-1:0]         SCALE_RST     = 7'd10;

    localparam logic [LR_W-1:0] LR_MAX = 9'd256;

endpackage

FILE: design/epsilon_greedy_channel_learner_top.sv
// Epsilon-greedy channel learner. A step request (s_tuser low) explores when its draw is
// below explore_threshold and takes its own channel, otherwise it scans the value memory
// for the largest value (lowest channel on ties); it then forms a reward from the metric
// memory, moves the chosen value toward it and returns one result. A write request
// (s_tuser high) loads one metric entry and returns nothing. An exploiting step scans the
// value memory, reading one entry per cycle; an exploring step skips the scan. A result
// waits in the output register while the next request is taken. Value and metric entries
// read as zero until first written. Configuration writes are taken in any cycle.
module epsilon_greedy_channel_learner_top #(
    parameter int CHANNELS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // explore_draw[15:0], explore_channel[19:16], entry_index[23:20], metric_value[31:24]
    input  logic [egcl_pkg::S_TDATA_W-1:0]    s_tdata,
    // op
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // chosen_channel[3:0], explored[4], reward[20:5], new_value[44:21], zeros above
    output logic [egcl_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [egcl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [egcl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import egcl_pkg::*;

    localparam int CH_W      = $clog2(CHANNELS);
    localparam int CNT_W     = $clog2(CHANNELS + 1);
    localparam int CMP_W     = 7;
    localparam int XCH_SPAN  = 1 << CHAN_W;
    localparam int MOD_STEPS = XCH_SPAN / CHANNELS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [DRAW_W-1:0]          threshold_reg;
    logic [LR_W-1:0]            lr_reg;
    logic signed [REWARD_W-1:0] penalty_reg;
    logic [SCALE_W-1:0]         scale_reg;

    logic [CH_W-1:0]            ch_reg;
    logic [CH_W-1:0]            last_reg;
    logic [CNT_W-1:0]           scan_cnt_reg;
    logic signed [VALUE_W-1:0]  best_reg;
    logic                       explored_reg;
    logic                       repeat_reg;
    logic signed [VALUE_W-1:0]  v_cur_reg;
    logic signed [16:0]         prod_reg;
    logic signed [REWARD_W-1:0] reward_reg;
    logic signed [34:0]         upd_reg;
    logic                       out_valid_reg;
    logic [M_TDATA_W-1:0]       out_data_reg;

    logic [DRAW_W-1:0]          in_draw;
    logic [CHAN_W-1:0]          in_xch;
    logic [CHAN_W-1:0]          in_idx;
    logic signed [METRIC_W-1:0] in_metric;
    logic                       s_accept;
    logic                       out_free;
    logic                       out_load;

    logic [CMP_W-1:0]           xch_mod;
    logic                       met_we;
    logic signed [METRIC_W-1:0] met_a;
    logic signed [METRIC_W-1:0] met_b;
    logic                       val_we;
    logic [CH_W-1:0]            val_raddr;
    logic signed [VALUE_W-1:0]  val_rdata;
    logic signed [VALUE_W-1:0]  new_value;

    logic signed [16:0]         diff_ext;
    logic signed [16:0]         scale_ext;
    logic signed [REWARD_W-1:0] reward_sel;
    logic [LR_W-1:0]            lr_eff;
    logic signed [34:0]         delta_ext;
    logic signed [34:0]         lr_ext;

    assign in_draw   = s_tdata[15:0];
    assign in_xch    = s_tdata[19:16];
    assign in_idx    = s_tdata[23:20];
    assign in_metric = s_tdata[31:24];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = (state_reg == ST_DONE) && out_free;

    // explore channel reduced modulo the channel count
    always_comb begin
        xch_mod = {{(CMP_W - CHAN_W){1'b0}}, in_xch};
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (xch_mod >= CMP_W'(CHANNELS)) begin
                xch_mod = xch_mod - CMP_W'(CHANNELS);
            end
        end
    end

    assign met_we = s_accept && (s_tuser == OP_WRITE)
                    && ({{(CMP_W - CHAN_W){1'b0}}, in_idx} < CMP_W'(CHANNELS));

    egcl_metric_ram #(
        .DEPTH (CHANNELS),
        .AW    (CH_W)
    ) u_metric_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (met_we),
        .waddr   (CH_W'(in_idx)),
        .wdata   (in_metric),
        .raddr_a (ch_reg),
        .raddr_b (last_reg),
        .rdata_a (met_a),
        .rdata_b (met_b)
    );

    assign val_raddr = (state_reg == ST_SCAN) ? scan_cnt_reg[CH_W-1:0] : ch_reg;
    assign val_we    = out_load;

    egcl_value_ram #(
        .DEPTH (CHANNELS),
        .AW    (CH_W)
    ) u_value_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (val_we),
        .waddr   (ch_reg),
        .wdata   (new_value),
        .raddr   (val_raddr),
        .rdata   (val_rdata)
    );

    // reward and update arithmetic
    always_comb begin
        diff_ext  = 17'(met_a) - 17'(met_b);
        scale_ext = {{(17 - SCALE_W){1'b0}}, scale_reg};
        if (repeat_reg) begin
            reward_sel = penalty_reg;
        end else if (prod_reg > 17'sd32767) begin
            reward_sel = 16'sh7fff;
        end else if (prod_reg < -17'sd32768) begin
            reward_sel = -16'sh8000;
        end else begin
            reward_sel = prod_reg[15:0];
        end
        lr_eff    = (lr_reg > LR_MAX) ? LR_MAX : lr_reg;
        delta_ext = 35'($signed({reward_sel, 8'b0})) - 35'(v_cur_reg);
        lr_ext    = {{(35 - LR_W){1'b0}}, lr_eff};
    end

    // the update stays between the old value and reward*256, so the low bits suffice
    assign new_value = v_cur_reg + upd_reg[31:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
            threshold_reg <= THRESHOLD_RST;
            lr_reg        <= LR_RST;
            penalty_reg   <= PENALTY_RST;
            scale_reg     <= SCALE_RST;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_EXPLORE_THRESHOLD: threshold_reg <= cfg_data[DRAW_W-1:0];
                    REG_LEARNING_RATE:     lr_reg        <= cfg_data[LR_W-1:0];
                    REG_REPEAT_PENALTY:    penalty_reg   <= cfg_data[REWARD_W-1:0];
                    REG_REWARD_SCALE:      scale_reg     <= cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_tuser == OP_STEP)) begin
                        if (in_draw < threshold_reg) begin
                            explored_reg <= 1'b1;
                            ch_reg       <= xch_mod[CH_W-1:0];
                            state_reg    <= ST_READ;
                        end else begin
                            explored_reg <= 1'b0;
                            ch_reg       <= '0;
                            scan_cnt_reg <= '0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // data of entry scan_cnt-1 arrives while scan_cnt is addressed
                    if (scan_cnt_reg != '0) begin
                        if (scan_cnt_reg == CNT_W'(1) || val_rdata > best_reg) begin
                            best_reg <= val_rdata;
                            ch_reg   <= CH_W'(scan_cnt_reg - CNT_W'(1));
                        end
                    end
                    if (scan_cnt_reg == CNT_W'(CHANNELS)) begin
                        state_reg <= ST_READ;
                    end else begin
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    end
                end
                ST_READ: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    v_cur_reg  <= val_rdata;
                    prod_reg   <= diff_ext * scale_ext;
                    repeat_reg <= (ch_reg == last_reg);
                    state_reg  <= ST_UPD;
                end
                ST_UPD: begin
                    reward_reg <= reward_sel;
                    upd_reg    <= lr_ext * delta_ext;
                    state_reg  <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        last_reg     <= ch_reg;
                        out_data_reg <= {3'b0, new_value, reward_reg, explored_reg,
                                         CHAN_W'(ch_reg)};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser == OP_WRITE) && !out_valid_reg) |=> !out_valid_reg)
        else $error("write request produced a result");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the finishing step");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= CNT_W'(CHANNELS)))
        else $error("scan counter ran past the channel count");

    a_value_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        val_we |-> (int'(ch_reg) < CHANNELS))
        else $error("value write to a channel out of range");

endmodule

FILE: design/egcl_metric_ram.sv
module egcl_metric_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                we,
    input  logic [AW-1:0]                       waddr,
    input  logic signed [egcl_pkg::METRIC_W-1:0] wdata,
    input  logic [AW-1:0]                       raddr_a,
    input  logic [AW-1:0]                       raddr_b,
    output logic signed [egcl_pkg::METRIC_W-1:0] rdata_a,
    output logic signed [egcl_pkg::METRIC_W-1:0] rdata_b
);
    import egcl_pkg::*;

    logic signed [METRIC_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic signed [METRIC_W-1:0] rdata_a_reg;
    logic signed [METRIC_W-1:0] rdata_b_reg;
    logic                       rvalid_a_reg;
    logic                       rvalid_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rvalid_a_reg <= 1'b0;
            rvalid_b_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_a_reg <= valid_reg[raddr_a];
            rvalid_b_reg <= valid_reg[raddr_b];
        end
    end

    assign rdata_a = rvalid_a_reg ? rdata_a_reg : '0;
    assign rdata_b = rvalid_b_reg ? rdata_b_reg : '0;

endmodule

FILE: design/egcl_value_ram.sv
module egcl_value_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [egcl_pkg::VALUE_W-1:0] wdata,
    input  logic [AW-1:0]                      raddr,
    output logic signed [egcl_pkg::VALUE_W-1:0] rdata
);
    import egcl_pkg::*;

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]          valid_reg;
    logic signed [VALUE_W-1:0] rdata_reg;
    logic                      rvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: verif/testbench.sv
module testbench;
    import egcl_pkg::*;

    localparam int NUM_CH        = 16;
    localparam int SETTLE_CYCLES = 2 * NUM_CH + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 195;

    localparam logic [CFG_IDX_W-1:0] REG_LAST_IDX = 4'hF;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  new_value;
        logic signed [REWARD_W-1:0] reward;
        logic                       explored;
        logic [CHAN_W-1:0]          channel;
    } pick_t;

    typedef enum logic [1:0] {ROW_STEP, ROW_WRITE, ROW_REG} row_kind_e;

    typedef struct {
        row_kind_e              kind;
        logic [S_TDATA_W-1:0]   word;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        bit                     typed;
        pick_t                  want;
    } plan_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // learner state as the testbench sees it
    logic signed [VALUE_W-1:0]  q_est [NUM_CH];
    logic signed [METRIC_W-1:0] rssi_mem [NUM_CH];
    logic [CHAN_W-1:0]          prev_chan;
    logic [DRAW_W-1:0]          thr_cfg;
    logic [LR_W-1:0]            lr_cfg;
    logic signed [REWARD_W-1:0] pen_cfg;
    logic [SCALE_W-1:0]         scale_cfg;

    pick_t     expected_picks [$];
    plan_row_t plan [$];
    pick_t     seen_pick;
    pick_t     want_pick;
    int        mismatches;
    int        src_idle_pct;
    int        snk_idle_pct;
    bit        hold_pending;

    epsilon_greedy_channel_learner_top #(
        .CHANNELS(NUM_CH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic pick_t predict_pick(input logic [DRAW_W-1:0] draw,
                                           input logic [CHAN_W-1:0] xch);
        pick_t  p;
        int     best;
        longint rw;
        longint v;
        longint lr_eff;
        if (draw < thr_cfg) begin
            p.explored = 1'b1;
            best = xch;
        end else begin
            p.explored = 1'b0;
            best = 0;
            for (int i = 1; i < NUM_CH; i++)
                if (q_est[i] > q_est[best]) best = i;
        end
        if (best == prev_chan) begin
            rw = pen_cfg;
        end else begin
            rw = (longint'(rssi_mem[best]) - longint'(rssi_mem[prev_chan]))
                 * longint'(scale_cfg);
            if (rw > 32767) rw = 32767;
            if (rw < -32768) rw = -32768;
        end
        lr_eff = (lr_cfg > LR_MAX) ? LR_MAX : lr_cfg;
        v = q_est[best];
        v = v + ((lr_eff * (rw * 256 - v)) >>> 8);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        q_est[best] = VALUE_W'(v);
        prev_chan = CHAN_W'(best);
        p.channel = CHAN_W'(best);
        p.reward = REWARD_W'(rw);
        p.new_value = VALUE_W'(v);
        return p;
    endfunction

    function automatic plan_row_t mk_step(input logic [DRAW_W-1:0] draw,
                                          input logic [CHAN_W-1:0] xch,
                                          input bit typed, input pick_t want);
        plan_row_t r;
        r.kind = ROW_STEP;
        r.word = {METRIC_W'($urandom), CHAN_W'($urandom), xch, draw};
        r.reg_idx = '0;
        r.reg_data = '0;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic plan_row_t mk_write(input logic [CHAN_W-1:0] idx,
                                           input logic [METRIC_W-1:0] metric);
        plan_row_t r;
        r.kind = ROW_WRITE;
        r.word = {metric, idx, CHAN_W'($urandom), DRAW_W'($urandom)};
        r.reg_idx = '0;
        r.reg_data = '0;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t mk_reg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        plan_row_t r;
        r.kind = ROW_REG;
        r.word = '0;
        r.reg_idx = idx;
        r.reg_data = data;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg(input logic [CFG_DATA_W-1:0] lo_end,
                                                       input logic [CFG_DATA_W-1:0] hi_end);
        case ($urandom_range(0, 3))
            0: return lo_end;
            1: return hi_end;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // offer one request, then fold it into the predicted state once it is taken
    task automatic issue_request(input logic op, input logic [S_TDATA_W-1:0] word,
                                 input bit typed, input pick_t want);
        pick_t p;
        @(negedge aclk);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_WRITE) begin
            rssi_mem[word[23:20]] = word[31:24];
        end else begin
            p = predict_pick(word[15:0], word[19:16]);
            expected_picks.push_back(typed ? want : p);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_EXPLORE_THRESHOLD: thr_cfg = data[DRAW_W-1:0];
            REG_LEARNING_RATE:     lr_cfg = data[LR_W-1:0];
            REG_REPEAT_PENALTY:    pen_cfg = data[REWARD_W-1:0];
            REG_REWARD_SCALE:      scale_cfg = data[SCALE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // stop offering and wait until the learner has nothing left in flight
    task automatic settle_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_picks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [METRIC_W-1:0] m;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_STEP;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        aresetn = 1'b0;
        mismatches = 0;
        hold_pending = 1'b0;
        src_idle_pct = 20;
        snk_idle_pct = 5;
        thr_cfg = THRESHOLD_RST;
        lr_cfg = LR_RST;
        pen_cfg = PENALTY_RST;
        scale_cfg = SCALE_RST;
        prev_chan = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            q_est[i] = '0;
            rssi_mem[i] = '0;
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // every metric entry gets written before any step can read it
        for (int i = 0; i < NUM_CH; i++) begin
            m = (i == 0) ? 8'h80 : (i == NUM_CH - 1) ? 8'h7F : METRIC_W'($urandom);
            issue_request(OP_WRITE, {m, CHAN_W'(i), CHAN_W'($urandom), DRAW_W'($urandom)},
                          1'b0, '0);
        end

        plan.push_back(mk_step(16'hFFFF, 4'd0, 1'b1,
            '{channel: 4'd0, explored: 1'b0, reward: -16'sd10, new_value: -24'sd260}));
        plan.push_back(mk_step(16'h0000, 4'd15, 1'b1,
            '{channel: 4'd15, explored: 1'b1, reward: 16'sd2550, new_value: 24'sd66300}));
        plan.push_back(mk_step(16'hFFFF, 4'd0, 1'b0, '0));
        plan.push_back(mk_write(4'd3, 8'h7F));
        plan.push_back(mk_write(4'd0, 8'h80));
        plan.push_back(mk_step(THRESHOLD_RST - 16'd1, 4'd3, 1'b0, '0));
        plan.push_back(mk_step(THRESHOLD_RST, 4'd3, 1'b0, '0));
        plan.push_back(mk_step(16'h0000, 4'd3, 1'b0, '0));
        // learning rate beyond full weight, plus writes to unused indexes
        plan.push_back(mk_reg(REG_LEARNING_RATE, 16'hFFFF));
        plan.push_back(mk_reg(REG_REWARD_SCALE + 4'd1, 16'hFFFF));
        plan.push_back(mk_reg(REG_LAST_IDX, 16'hFFFF));
        plan.push_back(mk_step(16'h0000, 4'd0, 1'b0, '0));
        plan.push_back(mk_reg(REG_EXPLORE_THRESHOLD, 16'h0000));
        plan.push_back(mk_step(16'h0000, 4'd9, 1'b0, '0));
        plan.push_back(mk_reg(REG_EXPLORE_THRESHOLD, 16'hFFFF));
        plan.push_back(mk_step(16'hFFFE, 4'd7, 1'b0, '0));
        plan.push_back(mk_step(16'hFFFF, 4'd7, 1'b0, '0));
        plan.push_back(mk_reg(REG_REPEAT_PENALTY, 16'h8000));
        plan.push_back(mk_reg(REG_REWARD_SCALE, 16'hFFFF));
        plan.push_back(mk_reg(REG_LEARNING_RATE, 16'h0000));
        plan.push_back(mk_step(16'h0000, 4'd7, 1'b0, '0));
        plan.push_back(mk_step(16'h0000, 4'd7, 1'b0, '0));
        plan.push_back(mk_write(4'd5, 8'hFF));
        plan.push_back(mk_step(16'h0000, 4'd5, 1'b0, '0));
        plan.push_back(mk_reg(REG_LEARNING_RATE, 16'h0100));
        plan.push_back(mk_reg(REG_REPEAT_PENALTY, 16'h0000));
        plan.push_back(mk_reg(REG_REWARD_SCALE, 16'h0000));
        // full weight with zero reward wipes the value
        plan.push_back(mk_step(16'h0000, 4'd5, 1'b1,
            '{channel: 4'd5, explored: 1'b1, reward: 16'sd0, new_value: 24'sd0}));
        plan.push_back(mk_step(16'h0000, 4'd6, 1'b1,
            '{channel: 4'd6, explored: 1'b1, reward: 16'sd0, new_value: 24'sd0}));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                settle_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                issue_request(plan[i].kind == ROW_WRITE ? OP_WRITE : OP_STEP, plan[i].word,
                              plan[i].typed, plan[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_idle();
            write_reg(REG_EXPLORE_THRESHOLD, pick_reg(16'h0000, 16'hFFFF));
            write_reg(REG_LEARNING_RATE, pick_reg(16'h0000, 16'h0100));
            write_reg(REG_REPEAT_PENALTY, pick_reg(16'h8000, 16'h0000));
            write_reg(REG_REWARD_SCALE, pick_reg(16'h0000, 16'h007F));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_REWARD_SCALE + 1, REG_LAST_IDX)),
                          CFG_DATA_W'($urandom));
            if (ph == NUM_PHASES - 1) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = 15 * $urandom_range(0, 2);
                snk_idle_pct = 5 * $urandom_range(0, 2);
            end
            // long output stall while requests keep coming
            if (ph == 2) begin
                src_idle_pct = 0;
                hold_pending = 1'b1;
            end
            repeat (PHASE_ITEMS)
                issue_request(($urandom_range(0, 3) == 0) ? OP_WRITE : OP_STEP,
                              S_TDATA_W'($urandom), 1'b0, '0);
        end

        settle_idle();
        if (mismatches == 0)
            $display("epsilon_greedy_channel_learner_top: match");
        else
            $display("epsilon_greedy_channel_learner_top: mismatch");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if ($urandom_range(0, 99) < snk_idle_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_picks.size() == 0) begin
                report_mismatch("result with nothing pending", longint'(m_tdata), 0);
            end else begin
                want_pick = expected_picks.pop_front();
                seen_pick = m_tdata[$bits(pick_t)-1:0];
                if (seen_pick.channel !== want_pick.channel)
                    report_mismatch("chosen_channel", seen_pick.channel, want_pick.channel);
                if (seen_pick.explored !== want_pick.explored)
                    report_mismatch("explored", seen_pick.explored, want_pick.explored);
                if (seen_pick.reward !== want_pick.reward)
                    report_mismatch("reward", seen_pick.reward, want_pick.reward);
                if (seen_pick.new_value !== want_pick.new_value)
                    report_mismatch("new_value", seen_pick.new_value, want_pick.new_value);
                if (m_tdata[M_TDATA_W-1:$bits(pick_t)] !== '0)
                    report_mismatch("m_tdata padding", m_tdata[M_TDATA_W-1:$bits(pick_t)], 0);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("epsilon_greedy_channel_learner_top: mismatch");
        $finish;
    end

endmodule

FILE: files.f
design/egcl_pkg.sv
design/egcl_metric_ram.sv
design/egcl_value_ram.sv
design/epsilon_greedy_channel_learner_top.sv
verif/testbench.sv
